@@ rtl/core/msdtt_pkg.sv @@
// Shared types and constants for the multi-slot deadline timer table.
package msdtt_pkg;

  localparam int unsigned ModeW     = 2;
  localparam int unsigned OwnerW    = 8;
  localparam int unsigned DelayW    = 48;
  localparam int unsigned TokenW    = 32;
  localparam int unsigned NowW      = 62;
  localparam int unsigned DeadlineW = 63;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned SlotOutW  = 4;
  localparam int unsigned WindowW   = 30;

  localparam logic [WindowW-1:0] WindowReset = 30'd1000000;

  // at most this many fires per dispatch
  localparam int unsigned MaxFires = 16;
  localparam int unsigned FireCntW = 5;

  localparam logic [ModeW-1:0] ModeSched    = 2'd0;
  localparam logic [ModeW-1:0] ModeRemove   = 2'd1;
  localparam logic [ModeW-1:0] ModeDispatch = 2'd2;
  localparam logic [ModeW-1:0] ModeQuery    = 2'd3;

  localparam logic [StatusW-1:0] StatDone     = 3'd0;
  localparam logic [StatusW-1:0] StatFull     = 3'd1;
  localparam logic [StatusW-1:0] StatNoDelay  = 3'd2;
  localparam logic [StatusW-1:0] StatNotFound = 3'd3;
  localparam logic [StatusW-1:0] StatFired    = 3'd4;
  localparam logic [StatusW-1:0] StatNoFire   = 3'd5;
  localparam logic [StatusW-1:0] StatTimeLeft = 3'd6;
  localparam logic [StatusW-1:0] StatNoPend   = 3'd7;

  typedef enum logic [1:0] {
    StIdle,
    StSched,
    StScan,
    StFin
  } state_e;

  typedef struct packed {
    logic [OwnerW-1:0]    owner;
    logic [TokenW-1:0]    token;
    logic [DeadlineW-1:0] deadline;
    logic [DelayW-1:0]    period;
  } entry_t;

endpackage

@@ rtl/core/msdtt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module msdtt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/multi_slot_deadline_timer_table.sv @@
// Top level of the multi-slot deadline timer table.
//
// Input channel (in_valid_i / in_stall_o) takes one command beat: schedule,
// remove, dispatch or query. The block holds in_stall_o high while it works
// on a command, then drops it. Output beats leave through a register
// (out_valid_o / out_stall_i); the last beat of a command carries last_o.
// Schedule registers its result in StSched once the output register is free,
// then returns to idle; it picks the lowest free slot from the busy flags.
// Remove, dispatch and query each walk the slot memory once, one read a
// cycle unless a held fire stalls the walk, and register their last result
// from StFin once the output register is free. A dispatch that fires
// several slots holds one fired beat back until the next is known, so last_o
// can be set on the final one; a stalled receiver holds the next fire and the walk.
// Slot contents live in one RAM of SLOTS entries; busy flags are flip-flops.
// Reset frees every slot and sets fire_window to 1000000 ns; the RAM needs
// no clearing. cfg_we_i writes fire_window; do so only while idle.
module multi_slot_deadline_timer_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [msdtt_pkg::WindowW-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [msdtt_pkg::ModeW-1:0]        mode_i,
  input  logic [msdtt_pkg::OwnerW-1:0]       owner_id_i,
  input  logic [msdtt_pkg::DelayW-1:0]       first_delay_i,
  input  logic                               has_first_i,
  input  logic [msdtt_pkg::DelayW-1:0]       repeat_interval_i,
  input  logic                               has_repeat_i,
  input  logic [msdtt_pkg::TokenW-1:0]       token_i,
  input  logic [msdtt_pkg::NowW-1:0]         now_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [msdtt_pkg::StatusW-1:0]      status_o,
  output logic [msdtt_pkg::SlotOutW-1:0]     slot_index_o,
  output logic [msdtt_pkg::OwnerW-1:0]       out_owner_o,
  output logic [msdtt_pkg::TokenW-1:0]       out_token_o,
  output logic [msdtt_pkg::DelayW-1:0]       time_left_o,
  output logic                               last_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned EntW = $bits(msdtt_pkg::entry_t);
  localparam int unsigned DlW  = msdtt_pkg::DeadlineW;

  // ---------------------------------------------------------------- state
  msdtt_pkg::state_e state_q, state_d;

  logic [msdtt_pkg::WindowW-1:0] window_q;
  logic [SLOTS-1:0]              busy_q, busy_d;

  logic [msdtt_pkg::ModeW-1:0]   mode_q;
  logic [msdtt_pkg::OwnerW-1:0]  owner_q;
  logic [msdtt_pkg::DelayW-1:0]  first_q;
  logic                          has_first_q;
  logic [msdtt_pkg::DelayW-1:0]  rep_q;
  logic                          has_rep_q;
  logic [msdtt_pkg::TokenW-1:0]  token_q;
  logic [msdtt_pkg::NowW-1:0]    now_q;
  logic [DlW-1:0]                limit_q;

  logic [CntW-1:0]               rd_idx_q, rd_idx_d;
  logic                          ev_valid_q, ev_valid_d;
  logic [IdxW-1:0]               ev_idx_q, ev_idx_d;

  logic                          found_q, found_d;
  logic [IdxW-1:0]               found_idx_q, found_idx_d;
  logic                          min_valid_q, min_valid_d;
  logic [DlW-1:0]                min_dl_q, min_dl_d;
  logic [IdxW-1:0]               min_idx_q, min_idx_d;
  logic [msdtt_pkg::FireCntW-1:0] fire_cnt_q, fire_cnt_d;

  logic                          pend_valid_q, pend_valid_d;
  logic [IdxW-1:0]               pend_idx_q, pend_idx_d;
  logic [msdtt_pkg::OwnerW-1:0]  pend_owner_q, pend_owner_d;
  logic [msdtt_pkg::TokenW-1:0]  pend_token_q, pend_token_d;

  logic                          out_valid_q, out_valid_d;
  logic [msdtt_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic [msdtt_pkg::SlotOutW-1:0] out_slot_q, out_slot_d;
  logic [msdtt_pkg::OwnerW-1:0]  out_owner_q, out_owner_d;
  logic [msdtt_pkg::TokenW-1:0]  out_token_q, out_token_d;
  logic [msdtt_pkg::DelayW-1:0]  out_left_q, out_left_d;
  logic                          out_last_q, out_last_d;

  // ------------------------------------------------------------ memory io
  logic                ram_we, ram_re;
  logic [IdxW-1:0]     ram_waddr, ram_raddr;
  msdtt_pkg::entry_t   ram_wdata, rd_entry;
  logic [EntW-1:0]     ram_rdata;

  msdtt_ram #(
    .Width (EntW),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = msdtt_pkg::entry_t'(ram_rdata);

  // ------------------------------------------------------------ helpers
  logic in_accept, out_free, scan_end;
  logic free_found;
  logic [IdxW-1:0] free_idx;

  assign in_stall_o = (state_q != msdtt_pkg::StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign scan_end   = !ev_valid_q && (rd_idx_q == CntW'(SLOTS));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  function automatic logic [msdtt_pkg::SlotOutW-1:0] slot_out(input logic [IdxW-1:0] idx);
    logic [IdxW+msdtt_pkg::SlotOutW-1:0] ext;
    ext = {{msdtt_pkg::SlotOutW{1'b0}}, idx};
    return ext[msdtt_pkg::SlotOutW-1:0];
  endfunction

  // ----------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msdtt_pkg::StIdle: begin
        if (in_accept) begin
          state_d = (mode_i == msdtt_pkg::ModeSched) ? msdtt_pkg::StSched
                                                      : msdtt_pkg::StScan;
        end
      end
      msdtt_pkg::StSched: begin
        if (out_free) state_d = msdtt_pkg::StIdle;
      end
      msdtt_pkg::StScan: begin
        if (scan_end) state_d = msdtt_pkg::StFin;
      end
      msdtt_pkg::StFin: begin
        if (out_free) state_d = msdtt_pkg::StIdle;
      end
      default: state_d = msdtt_pkg::StIdle;
    endcase
  end

  // ------------------------------------------------------------- datapath
  logic           ev_busy, ev_fire, advance;
  logic [DlW-1:0] sched_dl, rearm_dl, left_diff;
  logic [msdtt_pkg::DelayW-1:0] left_sat;

  assign ev_busy  = busy_q[ev_idx_q];
  assign ev_fire  = ev_valid_q && (mode_q == msdtt_pkg::ModeDispatch) && ev_busy &&
                    (rd_entry.deadline < limit_q) &&
                    (fire_cnt_q < msdtt_pkg::FireCntW'(msdtt_pkg::MaxFires));
  // a second fire needs the held beat to move to the output register first
  assign advance  = !(ev_fire && pend_valid_q && !out_free);

  assign sched_dl  = {1'b0, now_q} + DlW'(has_first_q ? first_q : rep_q);
  assign rearm_dl  = {1'b0, now_q} + DlW'(rd_entry.period);
  assign left_diff = min_dl_q - {1'b0, now_q};

  always_comb begin
    if (min_dl_q <= {1'b0, now_q}) begin
      left_sat = '0;
    end else if (|left_diff[DlW-1:msdtt_pkg::DelayW]) begin
      left_sat = '1;
    end else begin
      left_sat = left_diff[msdtt_pkg::DelayW-1:0];
    end
  end

  always_comb begin
    busy_d       = busy_q;
    rd_idx_d     = rd_idx_q;
    ev_valid_d   = ev_valid_q;
    ev_idx_d     = ev_idx_q;
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    min_valid_d  = min_valid_q;
    min_dl_d     = min_dl_q;
    min_idx_d    = min_idx_q;
    fire_cnt_d   = fire_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    pend_owner_d = pend_owner_q;
    pend_token_d = pend_token_q;

    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_owner_d  = out_owner_q;
    out_token_d  = out_token_q;
    out_left_d   = out_left_q;
    out_last_d   = out_last_q;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = rd_entry;
    ram_re    = 1'b0;
    ram_raddr = rd_idx_q[IdxW-1:0];

    unique case (state_q)
      msdtt_pkg::StIdle: begin
        if (in_accept) begin
          rd_idx_d     = '0;
          ev_valid_d   = 1'b0;
          found_d      = 1'b0;
          min_valid_d  = 1'b0;
          fire_cnt_d   = '0;
          pend_valid_d = 1'b0;
        end
      end

      msdtt_pkg::StSched: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_slot_d   = '0;
          out_owner_d  = '0;
          out_token_d  = '0;
          out_left_d   = '0;
          out_last_d   = 1'b1;
          if (!has_first_q && !has_rep_q) begin
            out_status_d = msdtt_pkg::StatNoDelay;
          end else if (!free_found) begin
            out_status_d = msdtt_pkg::StatFull;
          end else begin
            out_status_d       = msdtt_pkg::StatDone;
            out_slot_d         = slot_out(free_idx);
            busy_d[free_idx]   = 1'b1;
            ram_we             = 1'b1;
            ram_waddr          = free_idx;
            ram_wdata.owner    = owner_q;
            ram_wdata.token    = token_q;
            ram_wdata.deadline = sched_dl;
            ram_wdata.period   = has_rep_q ? rep_q : '0;
          end
        end
      end

      msdtt_pkg::StScan: begin
        if (advance) begin
          if (ev_valid_q && ev_busy) begin
            if (!found_q && (rd_entry.owner == owner_q)) begin
              found_d     = 1'b1;
              found_idx_d = ev_idx_q;
            end
            if (!min_valid_q || (rd_entry.deadline < min_dl_q)) begin
              min_valid_d = 1'b1;
              min_dl_d    = rd_entry.deadline;
              min_idx_d   = ev_idx_q;
            end
          end
          if (ev_fire) begin
            fire_cnt_d = fire_cnt_q + 1'b1;
            if (pend_valid_q) begin
              out_valid_d  = 1'b1;
              out_status_d = msdtt_pkg::StatFired;
              out_slot_d   = slot_out(pend_idx_q);
              out_owner_d  = pend_owner_q;
              out_token_d  = pend_token_q;
              out_left_d   = '0;
              out_last_d   = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_idx_d   = ev_idx_q;
            pend_owner_d = rd_entry.owner;
            pend_token_d = rd_entry.token;
            if (rd_entry.period != '0) begin
              ram_we             = 1'b1;
              ram_waddr          = ev_idx_q;
              ram_wdata.deadline = rearm_dl;
            end else begin
              busy_d[ev_idx_q] = 1'b0;
            end
          end
          if (rd_idx_q != CntW'(SLOTS)) begin
            ram_re     = 1'b1;
            ev_valid_d = 1'b1;
            ev_idx_d   = rd_idx_q[IdxW-1:0];
            rd_idx_d   = rd_idx_q + 1'b1;
          end else begin
            ev_valid_d = 1'b0;
          end
        end
      end

      msdtt_pkg::StFin: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_slot_d  = '0;
          out_owner_d = '0;
          out_token_d = '0;
          out_left_d  = '0;
          out_last_d  = 1'b1;
          case (mode_q)
            msdtt_pkg::ModeRemove: begin
              if (found_q) begin
                out_status_d        = msdtt_pkg::StatDone;
                out_slot_d          = slot_out(found_idx_q);
                busy_d[found_idx_q] = 1'b0;
              end else begin
                out_status_d = msdtt_pkg::StatNotFound;
              end
            end
            msdtt_pkg::ModeDispatch: begin
              if (pend_valid_q) begin
                out_status_d = msdtt_pkg::StatFired;
                out_slot_d   = slot_out(pend_idx_q);
                out_owner_d  = pend_owner_q;
                out_token_d  = pend_token_q;
              end else begin
                out_status_d = msdtt_pkg::StatNoFire;
              end
            end
            default: begin
              if (min_valid_q) begin
                out_status_d = msdtt_pkg::StatTimeLeft;
                out_slot_d   = slot_out(min_idx_q);
                out_left_d   = left_sat;
              end else begin
                out_status_d = msdtt_pkg::StatNoPend;
              end
            end
          endcase
        end
      end

      default: ;
    endcase
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= msdtt_pkg::StIdle;
      window_q     <= msdtt_pkg::WindowReset;
      busy_q       <= '0;
      out_valid_q  <= 1'b0;
      ev_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      rd_idx_q     <= '0;
      found_q      <= 1'b0;
      min_valid_q  <= 1'b0;
      fire_cnt_q   <= '0;
    end else begin
      state_q      <= state_d;
      busy_q       <= busy_d;
      out_valid_q  <= out_valid_d;
      ev_valid_q   <= ev_valid_d;
      pend_valid_q <= pend_valid_d;
      rd_idx_q     <= rd_idx_d;
      found_q      <= found_d;
      min_valid_q  <= min_valid_d;
      fire_cnt_q   <= fire_cnt_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q      <= mode_i;
      owner_q     <= owner_id_i;
      first_q     <= first_delay_i;
      has_first_q <= has_first_i;
      rep_q       <= repeat_interval_i;
      has_rep_q   <= has_repeat_i;
      token_q     <= token_i;
      now_q       <= now_i;
      limit_q     <= {1'b0, now_i} + DlW'(window_q);
    end
    ev_idx_q     <= ev_idx_d;
    found_idx_q  <= found_idx_d;
    min_dl_q     <= min_dl_d;
    min_idx_q    <= min_idx_d;
    pend_idx_q   <= pend_idx_d;
    pend_owner_q <= pend_owner_d;
    pend_token_q <= pend_token_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_owner_q  <= out_owner_d;
    out_token_q  <= out_token_d;
    out_left_q   <= out_left_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign slot_index_o = out_slot_q;
  assign out_owner_o  = out_owner_q;
  assign out_token_o  = out_token_q;
  assign time_left_o  = out_left_q;
  assign last_o       = out_last_q;

endmodule
